[hw/rtl/pmmd_pkg.sv]
// Shared types, codes and column arithmetic of the plot column min/max decimator.
package pmmd_pkg;

   localparam int X_BITS    = 32;
   localparam int Y_BITS    = 16;
   localparam int FRAC_BITS = 16;
   localparam int COL_BITS  = 32;
   localparam int CSR_BITS  = 32;
   localparam int PROD_BITS = X_BITS + CSR_BITS;
   localparam int RND_BITS  = PROD_BITS - FRAC_BITS + 1;

   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
   localparam int RES_DEPTH   = 4;
   localparam int RPTR_BITS   = $clog2(RES_DEPTH);
   localparam int RCNT_BITS   = $clog2(RES_DEPTH + 1);
   localparam int ROLE_COUNT  = 4;

   localparam logic [1:0] KIND_START  = 2'd0;
   localparam logic [1:0] KIND_SAMPLE = 2'd1;
   localparam logic [1:0] KIND_FLUSH  = 2'd2;

   localparam logic [1:0] ROLE_FIRST = 2'd0;
   localparam logic [1:0] ROLE_MIN   = 2'd1;
   localparam logic [1:0] ROLE_MAX   = 2'd2;
   localparam logic [1:0] ROLE_LAST  = 2'd3;

   localparam logic [1:0] STATUS_OK          = 2'd0;
   localparam logic [1:0] STATUS_X_DECREASED = 2'd1;
   localparam logic [1:0] STATUS_ZERO_SCALE  = 2'd2;

   localparam logic [1:0] CSR_X_MIN        = 2'd0;
   localparam logic [1:0] CSR_PIXELS_PER_X = 2'd1;
   localparam logic [1:0] CSR_X_PER_PIXEL  = 2'd2;

   localparam logic [CSR_BITS-1:0] X_MIN_RESET        = CSR_BITS'(0);
   localparam logic [CSR_BITS-1:0] PIXELS_PER_X_RESET = CSR_BITS'(65536);
   localparam logic [CSR_BITS-1:0] X_PER_PIXEL_RESET  = CSR_BITS'(65536);

   typedef struct packed {
      logic [1:0]               kind;
      logic [X_BITS-1:0]        x;
      logic signed [Y_BITS-1:0] y;
   } req_item_type;

   typedef struct packed {
      logic [X_BITS-1:0]        point_x;
      logic signed [Y_BITS-1:0] point_y;
      logic [1:0]               role;
      logic                     last;
      logic [1:0]               status;
      logic [X_BITS-1:0]        bound_min_x;
      logic [X_BITS-1:0]        bound_max_x;
      logic signed [Y_BITS-1:0] bound_min_y;
      logic signed [Y_BITS-1:0] bound_max_y;
   } rsp_item_type;

   typedef struct packed {
      req_item_type        item;
      logic [COL_BITS-1:0] column;
   } work_item_type;

   typedef struct packed {
      logic          valid;
      work_item_type work;
   } work_push_type;

   // Round half away from zero, then saturate to the signed column range.
   function automatic logic [COL_BITS-1:0] column_from_product(
      input logic [PROD_BITS-1:0] prod,
      input logic                 neg
   );
      logic [COL_BITS:0] mag;
      logic [COL_BITS:0] sat_neg;
      logic [COL_BITS:0] max_pos;
      sat_neg = (COL_BITS+1)'(1) << (COL_BITS - 1);
      max_pos = sat_neg - (COL_BITS+1)'(1);
      if (|prod[PROD_BITS-1:COL_BITS+FRAC_BITS-1]) begin
         mag = sat_neg;
      end else begin
         mag = (COL_BITS+1)'(prod[COL_BITS+FRAC_BITS-2:FRAC_BITS])
             + (COL_BITS+1)'(prod[FRAC_BITS-1]);
      end
      if (neg) begin
         if (mag > sat_neg) begin
            mag = sat_neg;
         end
         return COL_BITS'(0) - mag[COL_BITS-1:0];
      end
      if (mag > max_pos) begin
         mag = max_pos;
      end
      return mag[COL_BITS-1:0];
   endfunction

endpackage

[hw/rtl/pmmd_front.sv]
// Front end: accepts transactions and maps each x to its display column.
module pmmd_front import pmmd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  req_item_type         req_item,
   output logic                 req_full,
   input  logic [CSR_BITS-1:0]  x_min,
   input  logic [CSR_BITS-1:0]  pixels_per_x,
   input  logic [QCNT_BITS-1:0] queue_count,
   output work_push_type        push
);

   logic                  accept;
   logic [QCNT_BITS:0]    reserved;

   logic                  v1_ff;
   req_item_type          it1_ff;
   logic                  neg1_ff;
   logic [X_BITS-1:0]     a1_ff;
   logic                  neg1_in;
   logic [X_BITS-1:0]     a1_in;

   logic                  v2_ff;
   req_item_type          it2_ff;
   logic                  neg2_ff;
   logic [PROD_BITS-1:0]  prod2_ff;
   logic [PROD_BITS-1:0]  prod2_in;

   // Hold back input while the queue cannot take everything in flight.
   assign reserved = (QCNT_BITS+1)'(queue_count) + (QCNT_BITS+1)'(v1_ff)
                   + (QCNT_BITS+1)'(v2_ff);
   assign req_full = reserved >= (QCNT_BITS+1)'(QUEUE_DEPTH);
   assign accept   = req_push & ~req_full;

   assign neg1_in  = req_item.x < x_min;
   assign a1_in    = neg1_in ? (x_min - req_item.x) : (req_item.x - x_min);
   assign prod2_in = PROD_BITS'(a1_ff) * PROD_BITS'(pixels_per_x);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
         v2_ff <= v1_ff;
      end
      it1_ff   <= req_item;
      neg1_ff  <= neg1_in;
      a1_ff    <= a1_in;
      it2_ff   <= it1_ff;
      neg2_ff  <= neg1_ff;
      prod2_ff <= prod2_in;
   end

   assign push.valid       = v2_ff;
   assign push.work.item   = it2_ff;
   assign push.work.column = column_from_product(prod2_ff, neg2_ff);

endmodule

[hw/rtl/pmmd_item_queue.sv]
// Short queue of classified transactions between the front end and the aggregator.
module pmmd_item_queue import pmmd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  work_push_type        push,
   input  logic                 pop,
   output work_item_type        head,
   output logic                 empty,
   output logic [QCNT_BITS-1:0] count
);

   work_item_type         mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff;
   logic [QPTR_BITS-1:0]  rd_ptr_ff;
   logic [QCNT_BITS-1:0]  count_ff;
   logic [QCNT_BITS-1:0]  count_in;

   assign count_in = count_ff + QCNT_BITS'(push.valid) - QCNT_BITS'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push.valid) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_BITS'(1);
         end
         count_ff <= count_in;
      end
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.work;
      end
   end

   assign head  = mem_ff[rd_ptr_ff];
   assign empty = count_ff == '0;
   assign count = count_ff;

endmodule

[hw/rtl/pmmd_back.sv]
// Aggregator: column state, running bounds, point x and the result queue.
module pmmd_back import pmmd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic [CSR_BITS-1:0] x_min,
   input  logic [CSR_BITS-1:0] pixels_per_x,
   input  logic [CSR_BITS-1:0] x_per_pixel,
   input  logic                q_empty,
   input  work_item_type       q_head,
   output logic                q_pop,
   input  logic                rsp_pop,
   output logic                rsp_empty,
   output rsp_item_type        rsp_item
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_EXEC = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_RND  = 3'd3;
   localparam logic [2:0] ST_SUM  = 3'd4;
   localparam logic [2:0] ST_EMIT = 3'd5;
   localparam logic [2:0] ST_ERR  = 3'd6;

   localparam logic [RND_BITS:0] X_SAT = (RND_BITS+1)'({X_BITS{1'b1}});

   logic [2:0]               state_ff, state_in;
   work_item_type            cur_ff, cur_in;
   logic                     series_fresh_ff, series_fresh_in;
   logic                     col_valid_ff, col_valid_in;
   logic [X_BITS-1:0]        prior_x_ff, prior_x_in;
   logic [COL_BITS-1:0]      open_col_ff, open_col_in;
   logic signed [Y_BITS-1:0] col_first_ff, col_first_in;
   logic signed [Y_BITS-1:0] col_last_ff, col_last_in;
   logic signed [Y_BITS-1:0] col_min_ff, col_min_in;
   logic signed [Y_BITS-1:0] col_max_ff, col_max_in;
   logic [X_BITS-1:0]        seen_x_low_ff, seen_x_low_in;
   logic [X_BITS-1:0]        seen_x_high_ff, seen_x_high_in;
   logic signed [Y_BITS-1:0] seen_y_low_ff, seen_y_low_in;
   logic signed [Y_BITS-1:0] seen_y_high_ff, seen_y_high_in;
   logic [COL_BITS-1:0]      em_col_ff, em_col_in;
   logic signed [Y_BITS-1:0] em_y_ff [ROLE_COUNT];
   logic signed [Y_BITS-1:0] em_y_in [ROLE_COUNT];
   logic [1:0]               err_status_ff, err_status_in;
   logic [PROD_BITS-1:0]     prod_ff, prod_in;
   logic [RND_BITS-1:0]      rnd_ff, rnd_in;
   logic [X_BITS-1:0]        px_ff, px_in;
   logic [1:0]               emit_idx_ff, emit_idx_in;

   rsp_item_type             res_q_ff [RES_DEPTH];
   logic [RPTR_BITS-1:0]     res_wr_ff, res_rd_ff;
   logic [RCNT_BITS-1:0]     res_cnt_ff;
   logic                     res_room;
   logic                     res_push;
   logic                     res_take;
   rsp_item_type             res_data;

   logic                     em_neg;
   logic [COL_BITS-1:0]      em_mag;
   logic [RND_BITS:0]        pos_sum;
   logic [X_BITS-1:0]        cx;
   logic signed [Y_BITS-1:0] cy;
   logic                     fresh;

   assign res_room = res_cnt_ff != RCNT_BITS'(RES_DEPTH);
   assign res_take = rsp_pop & (res_cnt_ff != '0);
   assign em_neg   = em_col_ff[COL_BITS-1];
   assign em_mag   = em_neg ? (COL_BITS'(0) - em_col_ff) : em_col_ff;
   assign pos_sum  = (RND_BITS+1)'(rnd_ff) + (RND_BITS+1)'(x_min);
   assign cx       = cur_ff.item.x;
   assign cy       = cur_ff.item.y;
   assign fresh    = series_fresh_ff;

   always_comb begin
      state_in        = state_ff;
      cur_in          = cur_ff;
      series_fresh_in = series_fresh_ff;
      col_valid_in    = col_valid_ff;
      prior_x_in      = prior_x_ff;
      open_col_in     = open_col_ff;
      col_first_in    = col_first_ff;
      col_last_in     = col_last_ff;
      col_min_in      = col_min_ff;
      col_max_in      = col_max_ff;
      seen_x_low_in   = seen_x_low_ff;
      seen_x_high_in  = seen_x_high_ff;
      seen_y_low_in   = seen_y_low_ff;
      seen_y_high_in  = seen_y_high_ff;
      em_col_in       = em_col_ff;
      em_y_in         = em_y_ff;
      err_status_in   = err_status_ff;
      prod_in         = prod_ff;
      rnd_in          = rnd_ff;
      px_in           = px_ff;
      emit_idx_in     = emit_idx_ff;
      q_pop           = 1'b0;
      res_push        = 1'b0;
      res_data        = '0;
      res_data.bound_min_x = seen_x_low_ff;
      res_data.bound_max_x = seen_x_high_ff;
      res_data.bound_min_y = seen_y_low_ff;
      res_data.bound_max_y = seen_y_high_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               cur_in   = q_head;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
            unique case (cur_ff.item.kind)
               KIND_START: begin
                  series_fresh_in = 1'b1;
               end
               KIND_FLUSH: begin
                  if (col_valid_ff) begin
                     em_col_in  = open_col_ff;
                     em_y_in[0] = col_first_ff;
                     em_y_in[1] = col_min_ff;
                     em_y_in[2] = col_max_ff;
                     em_y_in[3] = col_last_ff;
                     state_in   = ST_MUL;
                  end
               end
               KIND_SAMPLE: begin
                  if (pixels_per_x == '0 || x_per_pixel == '0) begin
                     err_status_in = STATUS_ZERO_SCALE;
                     state_in      = ST_ERR;
                  end else begin
                     if (fresh) begin
                        series_fresh_in = 1'b0;
                        seen_x_low_in   = cx;
                        seen_x_high_in  = cx;
                        seen_y_low_in   = cy;
                        seen_y_high_in  = cy;
                     end else begin
                        if (cx > seen_x_high_ff) seen_x_high_in = cx;
                        if (cx < seen_x_low_ff)  seen_x_low_in  = cx;
                        if (cy > seen_y_high_ff) seen_y_high_in = cy;
                        if (cy < seen_y_low_ff)  seen_y_low_in  = cy;
                     end
                     if (!fresh && cx < prior_x_ff) begin
                        err_status_in = STATUS_X_DECREASED;
                        state_in      = ST_ERR;
                     end else begin
                        prior_x_in = cx;
                        if (col_valid_ff && !fresh && cur_ff.column == open_col_ff) begin
                           col_last_in = cy;
                           if (cy < col_min_ff) col_min_in = cy;
                           if (cy > col_max_ff) col_max_in = cy;
                        end else begin
                           // Column changed: snapshot the old one for output.
                           if (col_valid_ff && !fresh) begin
                              em_col_in  = open_col_ff;
                              em_y_in[0] = col_first_ff;
                              em_y_in[1] = col_min_ff;
                              em_y_in[2] = col_max_ff;
                              em_y_in[3] = col_last_ff;
                              state_in   = ST_MUL;
                           end
                           col_valid_in = 1'b1;
                           open_col_in  = cur_ff.column;
                           col_first_in = cy;
                           col_last_in  = cy;
                           col_min_in   = cy;
                           col_max_in   = cy;
                        end
                     end
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_MUL: begin
            prod_in  = PROD_BITS'(em_mag) * PROD_BITS'(x_per_pixel);
            state_in = ST_RND;
         end
         ST_RND: begin
            rnd_in   = RND_BITS'(prod_ff[PROD_BITS-1:FRAC_BITS])
                     + RND_BITS'(prod_ff[FRAC_BITS-1]);
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if (em_neg) begin
               px_in = (rnd_ff > RND_BITS'(x_min)) ? X_BITS'(0)
                                                   : (x_min - rnd_ff[X_BITS-1:0]);
            end else begin
               px_in = (pos_sum > X_SAT) ? {X_BITS{1'b1}} : pos_sum[X_BITS-1:0];
            end
            emit_idx_in = ROLE_FIRST;
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            if (res_room) begin
               res_push         = 1'b1;
               res_data.point_x = px_ff;
               res_data.point_y = em_y_ff[emit_idx_ff];
               res_data.role    = emit_idx_ff;
               res_data.last    = emit_idx_ff == ROLE_LAST;
               res_data.status  = STATUS_OK;
               emit_idx_in      = emit_idx_ff + 2'd1;
               if (emit_idx_ff == ROLE_LAST) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_ERR: begin
            if (res_room) begin
               res_push        = 1'b1;
               res_data.last   = 1'b1;
               res_data.status = err_status_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         series_fresh_ff <= 1'b0;
         col_valid_ff    <= 1'b0;
         prior_x_ff      <= '0;
         open_col_ff     <= '0;
         col_first_ff    <= '0;
         col_last_ff     <= '0;
         col_min_ff      <= '0;
         col_max_ff      <= '0;
         seen_x_low_ff   <= '0;
         seen_x_high_ff  <= '0;
         seen_y_low_ff   <= '0;
         seen_y_high_ff  <= '0;
         res_wr_ff       <= '0;
         res_rd_ff       <= '0;
         res_cnt_ff      <= '0;
      end else begin
         state_ff        <= state_in;
         series_fresh_ff <= series_fresh_in;
         col_valid_ff    <= col_valid_in;
         prior_x_ff      <= prior_x_in;
         open_col_ff     <= open_col_in;
         col_first_ff    <= col_first_in;
         col_last_ff     <= col_last_in;
         col_min_ff      <= col_min_in;
         col_max_ff      <= col_max_in;
         seen_x_low_ff   <= seen_x_low_in;
         seen_x_high_ff  <= seen_x_high_in;
         seen_y_low_ff   <= seen_y_low_in;
         seen_y_high_ff  <= seen_y_high_in;
         if (res_push) begin
            res_wr_ff <= res_wr_ff + RPTR_BITS'(1);
         end
         if (res_take) begin
            res_rd_ff <= res_rd_ff + RPTR_BITS'(1);
         end
         res_cnt_ff <= res_cnt_ff + RCNT_BITS'(res_push) - RCNT_BITS'(res_take);
      end
      cur_ff        <= cur_in;
      em_col_ff     <= em_col_in;
      em_y_ff       <= em_y_in;
      err_status_ff <= err_status_in;
      prod_ff       <= prod_in;
      rnd_ff        <= rnd_in;
      px_ff         <= px_in;
      emit_idx_ff   <= emit_idx_in;
      if (res_push) begin
         res_q_ff[res_wr_ff] <= res_data;
      end
   end

   assign rsp_empty = res_cnt_ff == '0;
   assign rsp_item  = res_q_ff[res_rd_ff];

endmodule

[hw/rtl/plot_column_minmax_decimator.sv]
// Top level of the plot column min/max decimator: registers, front end, queue, aggregator.
// A transaction passes the front end's registers (v1, v2) and the item queue before the
// aggregator takes it; a column's points are queued after the point-x multiply, round and add.
// The aggregator fetches and executes one transaction at a time and takes the next only once
// the last one's column or error results are queued; a full result queue stalls it.
// Reset: synchronous; clears queues, column state and bounds and loads register defaults.
module plot_column_minmax_decimator import pmmd_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   input  req_item_type        req_item,
   output logic                req_full,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output rsp_item_type        rsp_item,
   input  logic                csr_write,
   input  logic [1:0]          csr_index,
   input  logic [CSR_BITS-1:0] csr_data
);

   logic [CSR_BITS-1:0]  x_min_ff;
   logic [CSR_BITS-1:0]  pixels_per_x_ff;
   logic [CSR_BITS-1:0]  x_per_pixel_ff;
   work_push_type        push;
   work_item_type        q_head;
   logic                 q_empty;
   logic                 q_pop;
   logic [QCNT_BITS-1:0] q_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_min_ff        <= X_MIN_RESET;
         pixels_per_x_ff <= PIXELS_PER_X_RESET;
         x_per_pixel_ff  <= X_PER_PIXEL_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_X_MIN:        x_min_ff        <= csr_data;
            CSR_PIXELS_PER_X: pixels_per_x_ff <= csr_data;
            CSR_X_PER_PIXEL:  x_per_pixel_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   pmmd_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_item     (req_item),
      .req_full     (req_full),
      .x_min        (x_min_ff),
      .pixels_per_x (pixels_per_x_ff),
      .queue_count  (q_count),
      .push         (push)
   );

   pmmd_item_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (q_pop),
      .head  (q_head),
      .empty (q_empty),
      .count (q_count)
   );

   pmmd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .x_min        (x_min_ff),
      .pixels_per_x (pixels_per_x_ff),
      .x_per_pixel  (x_per_pixel_ff),
      .q_empty      (q_empty),
      .q_head       (q_head),
      .q_pop        (q_pop),
      .rsp_pop      (rsp_pop),
      .rsp_empty    (rsp_empty),
      .rsp_item     (rsp_item)
   );

endmodule

[hw/rtl/pmmd_checker.sv]
// Port-level checks of the plot column min/max decimator, bound to the top level.
module pmmd_checker import pmmd_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_full,
   input logic         rsp_empty,
   input logic         rsp_pop,
   input rsp_item_type rsp_item
);

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

   a_error_no_point: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_item.status != STATUS_OK) |->
      (rsp_item.point_x == '0 && rsp_item.point_y == '0 &&
       rsp_item.role == ROLE_FIRST && rsp_item.last))
      else $error("error transaction carries a point");

   a_last_marks_role: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_item.status == STATUS_OK) |->
      (rsp_item.last == (rsp_item.role == ROLE_LAST)))
      else $error("last flag disagrees with role");

   a_bounds_ordered: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |->
      (rsp_item.bound_min_x <= rsp_item.bound_max_x &&
       $signed(rsp_item.bound_min_y) <= $signed(rsp_item.bound_max_y)))
      else $error("running bounds out of order");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_item)))
      else $error("waiting result changed");

endmodule

bind plot_column_minmax_decimator pmmd_checker u_pmmd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_item  (rsp_item)
);

[bench/testbench.sv]
// Self-checking testbench for the plot column min/max decimator.
module testbench;
   import pmmd_pkg::*;

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 40;

   // Tracks the decimator's column state and holds the points it must produce.
   class column_point_book;
      logic [X_BITS-1:0]        origin_x;
      logic [CSR_BITS-1:0]      cols_per_x;
      logic [CSR_BITS-1:0]      x_per_col;
      bit                       new_series;
      bit                       col_open;
      logic [X_BITS-1:0]        last_x;
      logic [COL_BITS-1:0]      cur_col;
      logic signed [Y_BITS-1:0] first_y, final_y, low_y, high_y;
      logic [X_BITS-1:0]        x_lo, x_hi;
      logic signed [Y_BITS-1:0] y_lo, y_hi;
      rsp_item_type             due_points[$];
      int fail_count, point_count, column_count, decrease_count, zero_scale_count;
      int kind_count[4];

      function new();
         origin_x = X_MIN_RESET;
         cols_per_x = PIXELS_PER_X_RESET;
         x_per_col = X_PER_PIXEL_RESET;
         new_series = 1'b0;
         col_open = 1'b0;
         last_x = '0;
         cur_col = '0;
         {first_y, final_y, low_y, high_y} = '0;
         {x_lo, x_hi, y_lo, y_hi} = '0;
         fail_count = 0;
         point_count = 0;
         column_count = 0;
         decrease_count = 0;
         zero_scale_count = 0;
         foreach (kind_count[k]) kind_count[k] = 0;
      endfunction

      function void set_reg(logic [1:0] index, logic [CSR_BITS-1:0] value);
         case (index)
            CSR_X_MIN:        origin_x = value;
            CSR_PIXELS_PER_X: cols_per_x = value;
            CSR_X_PER_PIXEL:  x_per_col = value;
            default: ;
         endcase
      endfunction

      // Signed column of x, rounded half away from zero and saturated.
      function logic [COL_BITS-1:0] map_column(logic [X_BITS-1:0] x);
         logic              below;
         logic [31:0]       span;
         logic [63:0]       prod;
         logic [32:0]       mag;
         below = x < origin_x;
         span = below ? origin_x - x : x - origin_x;
         prod = {32'd0, span} * {32'd0, cols_per_x};
         if (prod[63:47] != '0) begin
            mag = 33'h080000000;
         end else begin
            mag = {2'b00, prod[46:16]} + {32'd0, prod[15]};
         end
         if (below) begin
            if (mag > 33'h080000000) mag = 33'h080000000;
            return 32'd0 - mag[31:0];
         end
         if (mag > 33'h07FFFFFFF) mag = 33'h07FFFFFFF;
         return mag[31:0];
      endfunction

      // Point x of a column (column times x per pixel, from the origin), clamped to the unsigned x range.
      function logic [X_BITS-1:0] column_edge_x(logic [COL_BITS-1:0] col);
         logic [31:0] mag;
         logic [63:0] prod;
         logic [63:0] offset;
         mag = col[31] ? 32'd0 - col : col;
         prod = {32'd0, mag} * {32'd0, x_per_col};
         offset = (prod + 64'd32768) >> 16;
         if (col[31]) begin
            return (offset > {32'd0, origin_x}) ? '0 : origin_x - offset[31:0];
         end
         offset = offset + {32'd0, origin_x};
         return (offset > 64'hFFFFFFFF) ? '1 : offset[31:0];
      endfunction

      function void add_point(logic [X_BITS-1:0] px, logic signed [Y_BITS-1:0] py,
                              logic [1:0] role, logic last, logic [1:0] status);
         rsp_item_type p;
         p.point_x = px;
         p.point_y = py;
         p.role = role;
         p.last = last;
         p.status = status;
         p.bound_min_x = x_lo;
         p.bound_max_x = x_hi;
         p.bound_min_y = y_lo;
         p.bound_max_y = y_hi;
         due_points.push_back(p);
      endfunction

      function void add_column();
         logic [X_BITS-1:0] px;
         px = column_edge_x(cur_col);
         add_point(px, first_y, ROLE_FIRST, 1'b0, STATUS_OK);
         add_point(px, low_y, ROLE_MIN, 1'b0, STATUS_OK);
         add_point(px, high_y, ROLE_MAX, 1'b0, STATUS_OK);
         add_point(px, final_y, ROLE_LAST, 1'b1, STATUS_OK);
         column_count++;
      endfunction

      function void open_at(logic [COL_BITS-1:0] col, logic signed [Y_BITS-1:0] y);
         cur_col = col;
         {first_y, final_y, low_y, high_y} = {y, y, y, y};
         col_open = 1'b1;
      endfunction

      function void note_request(req_item_type it);
         logic [COL_BITS-1:0] col;
         kind_count[it.kind]++;
         if (it.kind == KIND_START) begin
            new_series = 1'b1;
            return;
         end
         if (it.kind == KIND_FLUSH) begin
            if (col_open) add_column();
            return;
         end
         if (it.kind != KIND_SAMPLE) return;
         if (cols_per_x == '0 || x_per_col == '0) begin
            add_point('0, '0, ROLE_FIRST, 1'b1, STATUS_ZERO_SCALE);
            zero_scale_count++;
            return;
         end
         if (new_series) begin
            // First sample of a series: drop the open column, restart the bounds.
            new_series = 1'b0;
            col_open = 1'b0;
            x_lo = it.x;
            x_hi = it.x;
            y_lo = it.y;
            y_hi = it.y;
         end else begin
            if (it.x > x_hi) x_hi = it.x;
            if (it.x < x_lo) x_lo = it.x;
            if ($signed(it.y) > y_hi) y_hi = it.y;
            if ($signed(it.y) < y_lo) y_lo = it.y;
            if (it.x < last_x) begin
               add_point('0, '0, ROLE_FIRST, 1'b1, STATUS_X_DECREASED);
               decrease_count++;
               return;
            end
         end
         last_x = it.x;
         col = map_column(it.x);
         if (!col_open) begin
            open_at(col, it.y);
         end else if (col == cur_col) begin
            final_y = it.y;
            if ($signed(it.y) < low_y) low_y = it.y;
            if ($signed(it.y) > high_y) high_y = it.y;
         end else begin
            add_column();
            open_at(col, it.y);
         end
      endfunction

      function void compare(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_count++;
         end
      endfunction

      function void check_point(rsp_item_type got);
         rsp_item_type want;
         if (due_points.size() == 0) begin
            $error("unexpected point: x %0h y %0h role %0d status %0d",
                   got.point_x, got.point_y, got.role, got.status);
            fail_count++;
            return;
         end
         want = due_points.pop_front();
         point_count++;
         compare("point_x", want.point_x, got.point_x);
         compare("point_y", want.point_y, got.point_y);
         compare("role", want.role, got.role);
         compare("last", want.last, got.last);
         compare("status", want.status, got.status);
         compare("bound_min_x", want.bound_min_x, got.bound_min_x);
         compare("bound_max_x", want.bound_max_x, got.bound_max_x);
         compare("bound_min_y", want.bound_min_y, got.bound_min_y);
         compare("bound_max_y", want.bound_max_y, got.bound_max_y);
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                req_push;
   req_item_type        req_item;
   logic                req_full;
   logic                rsp_empty;
   logic                rsp_pop;
   rsp_item_type        rsp_item;
   logic                csr_write;
   logic [1:0]          csr_index;
   logic [CSR_BITS-1:0] csr_data;

   column_point_book board;
   int burst_left = 0;
   int setting_count = 0;
   logic [15:0] pop_pattern = 16'hFFFF;
   int pop_age = 0;

   plot_column_minmax_decimator u_top (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_item  (req_item),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: rotate a stall pattern, reloading it now and then.
   always @(posedge clock) begin
      if (pop_age == 0) begin
         pop_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
         pop_age = 150;
      end
      pop_age--;
      pop_pattern = {pop_pattern[0], pop_pattern[15:1]};
      rsp_pop <= pop_pattern[0];
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) board.check_point(rsp_item);
   end

   function automatic req_item_type make_req(logic [1:0] kind, logic [X_BITS-1:0] x,
                                             logic [Y_BITS-1:0] y);
      req_item_type it;
      it.kind = kind;
      it.x = x;
      it.y = y;
      return it;
   endfunction

   // Send one transaction; the sender idles between bursts of random length.
   task automatic send(input req_item_type it);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 16);
         if (gap > 0) begin
            req_push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_push <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (req_full);
      board.note_request(it);
   endtask

   // Hold off until every expected point is out, then let queued work settle.
   task automatic drain();
      req_push <= 1'b0;
      while (board.due_points.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      burst_left = 0;
   endtask

   task automatic write_regs(input logic [CSR_BITS-1:0] origin, input logic [CSR_BITS-1:0] scale,
                             input logic [CSR_BITS-1:0] pitch);
      csr_write <= 1'b1;
      csr_index <= CSR_X_MIN;
      csr_data <= origin;
      @(posedge clock);
      board.set_reg(CSR_X_MIN, origin);
      csr_index <= CSR_PIXELS_PER_X;
      csr_data <= scale;
      @(posedge clock);
      board.set_reg(CSR_PIXELS_PER_X, scale);
      csr_index <= CSR_X_PER_PIXEL;
      csr_data <= pitch;
      @(posedge clock);
      board.set_reg(CSR_X_PER_PIXEL, pitch);
      csr_write <= 1'b0;
      setting_count++;
   endtask

   // Mostly well-formed series with non-decreasing x, mixed with noise.
   task automatic run_phase(input int goal);
      int sent, len, i, pick;
      int unsigned step_max;
      logic [32:0] nx;
      logic [X_BITS-1:0] x;
      step_max = (32'd65536 / board.cols_per_x) + 1;
      sent = 0;
      while (sent < goal) begin
         if ($urandom_range(0, 9) != 0) begin
            send(make_req(KIND_START, $urandom, Y_BITS'($urandom)));
            sent++;
         end
         if ($urandom_range(0, 1) == 1) begin
            x = $urandom;
         end else begin
            nx = {1'b0, board.origin_x} + $urandom_range(0, 8 * step_max);
            x = nx[32] ? '1 : nx[31:0];
         end
         len = $urandom_range(2, 14);
         for (i = 0; i < len; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
               send(make_req(KIND_UNUSED, $urandom, Y_BITS'($urandom)));
            end else if (pick < 9) begin
               send(make_req(KIND_SAMPLE, x - $urandom_range(1, 16), Y_BITS'($urandom)));
               sent++;
            end else if (pick < 13) begin
               send(make_req(KIND_FLUSH, $urandom, Y_BITS'($urandom)));
               sent++;
            end else if (pick < 15) begin
               drain();
            end else begin
               nx = {1'b0, x} + $urandom_range(0, step_max);
               x = nx[32] ? '1 : nx[31:0];
               send(make_req(KIND_SAMPLE, x, Y_BITS'($urandom)));
               sent++;
            end
         end
         if ($urandom_range(0, 4) != 0) begin
            send(make_req(KIND_FLUSH, $urandom, Y_BITS'($urandom)));
            sent++;
         end
      end
      drain();
   endtask

   initial begin
      #3000000;
      $display("FAIL");
      $finish;
   end

   initial begin
      board = new();
      reset <= 1'b1;
      req_push <= 1'b0;
      req_item <= '0;
      rsp_pop <= 1'b0;
      csr_write <= 1'b0;
      csr_index <= CSR_X_MIN;
      csr_data <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset scaling: one column per x unit.
      send(make_req(KIND_FLUSH, 32'hFFFFFFFF, 16'hFFFF));
      send(make_req(KIND_SAMPLE, 32'd5, 16'd7));
      send(make_req(KIND_FLUSH, 32'd0, 16'd0));
      send(make_req(KIND_FLUSH, 32'd0, 16'd0));
      send(make_req(KIND_UNUSED, 32'hFFFFFFFF, 16'h8000));
      send(make_req(KIND_START, 32'hFFFFFFFF, 16'h7FFF));
      send(make_req(KIND_SAMPLE, 32'd10, 16'h8000));
      send(make_req(KIND_SAMPLE, 32'd10, 16'h7FFF));
      send(make_req(KIND_SAMPLE, 32'd10, 16'h0000));
      send(make_req(KIND_SAMPLE, 32'd11, 16'd100));
      send(make_req(KIND_SAMPLE, 32'd3, 16'd5));
      send(make_req(KIND_START, 32'd0, 16'd0));
      send(make_req(KIND_SAMPLE, 32'hFFFFFFFF, 16'hFFFF));
      send(make_req(KIND_FLUSH, 32'd0, 16'd0));
      send(make_req(KIND_START, 32'd0, 16'd0));
      send(make_req(KIND_SAMPLE, 32'd0, 16'd1));
      drain();

      // Extreme scales around a mid-range origin.
      write_regs(32'h80000000, 32'hFFFFFFFF, 32'hFFFFFFFF);
      send(make_req(KIND_START, 32'd0, 16'd0));
      send(make_req(KIND_SAMPLE, 32'd0, 16'hFFFB));
      send(make_req(KIND_SAMPLE, 32'h80000000, 16'd9));
      send(make_req(KIND_SAMPLE, 32'hFFFFFFFF, 16'hFFF7));
      send(make_req(KIND_FLUSH, 32'd0, 16'd0));
      drain();

      // Zero scale on either register.
      write_regs(32'd0, 32'd0, 32'hFFFFFFFF);
      send(make_req(KIND_SAMPLE, 32'd1, 16'd1));
      drain();
      write_regs(32'd0, 32'd65536, 32'd0);
      send(make_req(KIND_SAMPLE, 32'd2, 16'd2));
      drain();

      write_regs($urandom_range(0, 1000), 32'd65536, 32'd65536);
      run_phase(34);
      write_regs($urandom, $urandom_range(1, 32'h40000), $urandom);
      run_phase(34);
      write_regs(32'hFFFFFFFF, 32'hFFFFFFFF, 32'd1);
      run_phase(34);
      write_regs(32'd0, 32'd1, 32'hFFFFFFFF);
      run_phase(34);
      write_regs($urandom, $urandom_range(1, 32'hFFFFFFFF), $urandom_range(1, 32'h20000));
      run_phase(34);

      $display("Sent %0d starts, %0d samples, %0d flushes, %0d unused kinds over %0d scalings.",
               board.kind_count[KIND_START], board.kind_count[KIND_SAMPLE],
               board.kind_count[KIND_FLUSH], board.kind_count[KIND_UNUSED], setting_count);
      $display("Checked %0d points: %0d columns, %0d decreasing-x, %0d zero-scale errors.",
               board.point_count, board.column_count, board.decrease_count,
               board.zero_scale_count);
      if (board.fail_count == 0 && board.due_points.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
